FILE: rtl/rnif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnif_pkg
// Types, numeral tables and register codes shared by the index formatter.
// ----------------------------------------------------------------------------
package rnif_pkg;

  localparam int unsigned NUM_DIGITS = 13;
  localparam int unsigned RUN_LIMIT  = 32;

  typedef logic [15:0] char_t;
  typedef logic [3:0]  digit_t;
  typedef logic [1:0]  cfg_index_t;

  // Configuration register indexes
  localparam cfg_index_t CFG_OPEN_BRACKET  = 2'd0;
  localparam cfg_index_t CFG_CLOSE_BRACKET = 2'd1;
  localparam cfg_index_t CFG_CAPITALS      = 2'd2;

  localparam char_t CASE_OFFSET = 16'd32;

  // Greedy numeral table, largest value first
  localparam logic [9:0] DIGIT_VALUE [NUM_DIGITS] = '{
    10'd1000, 10'd900, 10'd500, 10'd400, 10'd100, 10'd90, 10'd50,
    10'd40, 10'd10, 10'd9, 10'd5, 10'd4, 10'd1
  };
  localparam logic [7:0] DIGIT_FIRST [NUM_DIGITS] = '{
    "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
  };
  // Zero where the symbol has a single letter
  localparam logic [7:0] DIGIT_SECOND [NUM_DIGITS] = '{
    8'h00, "M", 8'h00, "D", 8'h00, "C", 8'h00, "L", 8'h00, "X", 8'h00,
    "V", 8'h00
  };

  typedef struct packed {
    logic load;
    logic put_open;
    logic put_first;
    logic put_second;
    logic put_close;
    logic next_digit;
    logic emit_char;
    logic emit_term;
    logic emit_err;
  } dp_cmd_t;

  typedef struct packed {
    logic has_value;
    logic num_zero;
    logic open_nz;
    logic close_nz;
    logic full;
    logic fits;
    logic two_letter;
    logic run_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/rnif_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnif_if
// Handshake channels of the index formatter: item words in, result words out.
// ----------------------------------------------------------------------------
interface rnif_in_if;
  logic        valid;
  logic        ready;
  logic        has_value;
  logic [15:0] value;

  modport source (output valid, output has_value, output value, input ready);
  modport sink   (input valid, input has_value, input value, output ready);
endinterface

interface rnif_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] character;
  logic        last;
  logic        error;

  modport source (output valid, output character, output last, output error, input ready);
  modport sink   (input valid, input character, input last, input error, output ready);
endinterface

FILE: rtl/rnif_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnif_ctrl
// Sequencer: builds the text in the line store, then streams it out.
// ----------------------------------------------------------------------------
module rnif_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  rnif_pkg::dp_stat_t stat,
  output rnif_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPEN  = 3'd1;
  localparam logic [2:0] S_NUM   = 3'd2;
  localparam logic [2:0] S_SEC   = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_PRE   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_ERR   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_OPEN;
        end
      end
      S_OPEN: begin
        if (stat.open_nz && stat.full) begin
          state_next = S_ERR;
        end else begin
          cmd.put_open = stat.open_nz;
          if (!stat.has_value) begin
            state_next = S_CLOSE;
          end else if (stat.num_zero) begin
            state_next = S_ERR;
          end else begin
            state_next = S_NUM;
          end
        end
      end
      S_NUM: begin
        priority if (stat.num_zero) begin
          state_next = S_CLOSE;
        end else if (stat.fits) begin
          if (stat.full) begin
            state_next = S_ERR;
          end else begin
            cmd.put_first = 1'b1;
            state_next    = stat.two_letter ? S_SEC : S_NUM;
          end
        end else begin
          cmd.next_digit = 1'b1;
        end
      end
      S_SEC: begin
        if (stat.full) begin
          state_next = S_ERR;
        end else begin
          cmd.put_second = 1'b1;
          state_next     = S_NUM;
        end
      end
      S_CLOSE: begin
        if (stat.close_nz && stat.full) begin
          state_next = S_ERR;
        end else begin
          cmd.put_close = stat.close_nz;
          state_next    = S_PRE;
        end
      end
      // a quiet state so the first stored word is read back
      S_PRE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          if (stat.run_done) begin
            cmd.emit_term = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.emit_char = 1'b1;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rnif_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnif_dp
// Datapath: config registers, numeral reduction, line store, result register.
// ----------------------------------------------------------------------------
module rnif_dp #(
  parameter int unsigned BUF_CHARS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rnif_pkg::dp_cmd_t     cmd,
  output rnif_pkg::dp_stat_t    stat,
  input  logic                  cfg_we,
  input  rnif_pkg::cfg_index_t  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  item_has_value,
  input  logic [15:0]           item_value,
  input  logic                  result_ready,
  output logic                  result_valid,
  output logic [15:0]           result_character,
  output logic                  result_last,
  output logic                  result_error
);

  localparam int unsigned TEXT_CAP =
    ((BUF_CHARS < rnif_pkg::RUN_LIMIT) ? BUF_CHARS : rnif_pkg::RUN_LIMIT) - 1;
  localparam int unsigned LEN_W = $clog2(TEXT_CAP + 1);
  localparam int unsigned AW    = $clog2(TEXT_CAP);
  localparam int unsigned DEPTH = 1 << AW;

  rnif_pkg::char_t  open_bracket;
  rnif_pkg::char_t  close_bracket;
  logic             capitals;

  logic             has_value;
  logic [15:0]      number;
  rnif_pkg::digit_t digit;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] rp;
  logic [LEN_W-1:0] rp_next;
  rnif_pkg::char_t  rd_data;
  rnif_pkg::char_t  line_store [DEPTH];

  logic [15:0]      digit_value;
  logic [7:0]       letter;
  rnif_pkg::char_t  letter_char;
  rnif_pkg::char_t  wr_data;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_bracket  <= '0;
      close_bracket <= '0;
      capitals      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rnif_pkg::CFG_OPEN_BRACKET:  open_bracket  <= cfg_data;
        rnif_pkg::CFG_CLOSE_BRACKET: close_bracket <= cfg_data;
        rnif_pkg::CFG_CAPITALS:      capitals      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign digit_value = {6'd0, rnif_pkg::DIGIT_VALUE[digit]};
  assign letter      = cmd.put_second ? rnif_pkg::DIGIT_SECOND[digit]
                                      : rnif_pkg::DIGIT_FIRST[digit];
  assign letter_char = {8'd0, letter} + (capitals ? 16'd0 : rnif_pkg::CASE_OFFSET);

  assign wr_en = cmd.put_open | cmd.put_first | cmd.put_second | cmd.put_close;

  always_comb begin
    priority if (cmd.put_open) begin
      wr_data = open_bracket;
    end else if (cmd.put_close) begin
      wr_data = close_bracket;
    end else begin
      wr_data = letter_char;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      has_value <= item_has_value;
      number    <= item_value;
      digit     <= '0;
      len       <= '0;
    end else begin
      if (cmd.put_first) begin
        number <= number - digit_value;
      end
      if (cmd.next_digit) begin
        digit <= digit + 4'd1;
      end
      if (wr_en) begin
        len <= len + LEN_W'(1);
      end
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[len[AW-1:0]] <= wr_data;
    end
    rd_data <= line_store[rp_next[AW-1:0]];
  end

  // read data tracks the word at the read pointer once no write to it is pending
  always_comb begin
    priority if (cmd.load) begin
      rp_next = '0;
    end else if (cmd.emit_char) begin
      rp_next = rp + LEN_W'(1);
    end else begin
      rp_next = rp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
    end else begin
      rp <= rp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_char | cmd.emit_term | cmd.emit_err) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_char | cmd.emit_term | cmd.emit_err) begin
      result_character <= cmd.emit_char ? rd_data : 16'd0;
      result_last      <= ~cmd.emit_char;
      result_error     <= cmd.emit_err;
    end
  end

  assign stat.has_value  = has_value;
  assign stat.num_zero   = (number == 16'd0);
  assign stat.open_nz    = (open_bracket != 16'd0);
  assign stat.close_nz   = (close_bracket != 16'd0);
  assign stat.full       = (len >= LEN_W'(TEXT_CAP));
  assign stat.fits       = (digit_value <= number);
  assign stat.two_letter = (rnif_pkg::DIGIT_SECOND[digit] != 8'h00);
  assign stat.run_done   = (rp == len);
  assign stat.out_free   = ~result_valid | result_ready;

endmodule

FILE: rtl/roman_numeral_index_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_index_formatter_unit
// Formats a list item number as [open bracket] Roman numeral [close bracket].
// ----------------------------------------------------------------------------
// Usage:
//   item   : one word per list item (has_value, value), taken when valid and
//            ready are high. ready is high only while no item is in work.
//   result : one word per character of the text, then a terminator word with
//            character 0 and last set. A zero value or text longer than
//            min(BUF_CHARS, 32) - 1 characters gives one word with last and
//            error set instead, and no characters.
//   cfg    : cfg_we writes cfg_data to register cfg_index (0 open bracket,
//            1 close bracket, 2 capitals). Write only while idle.
// Timing: the text is first assembled in the line store: a step to accept,
//   the open bracket step, a step per numeral letter and per skipped
//   table entry (at most 12), a step to leave the numeral (none with no
//   value), the close bracket step and a step to start the read-back. It
//   then streams one word per cycle while the receiver is ready: the
//   characters, then the terminator.
//   The single store write port sets the build rate.
// Reset clears the brackets to none and selects capitals; the line store is
//   not cleared. A stalled receiver holds the result word and the sequencer.
// ----------------------------------------------------------------------------
module roman_numeral_index_formatter_unit #(
  parameter int unsigned BUF_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  rnif_in_if.sink     item,
  rnif_out_if.source  result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rnif_pkg::dp_cmd_t  cmd;
  rnif_pkg::dp_stat_t stat;

  rnif_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rnif_dp #(
    .BUF_CHARS (BUF_CHARS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_has_value   (item.has_value),
    .item_value       (item.value),
    .result_ready     (result.ready),
    .result_valid     (result.valid),
    .result_character (result.character),
    .result_last      (result.last),
    .result_error     (result.error)
  );

endmodule

FILE: rtl/rnif_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnif_checker
// Port-level checks of the index formatter, bound onto the top level.
// ----------------------------------------------------------------------------
module rnif_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [15:0] result_character,
  input logic        result_last,
  input logic        result_error
);

  // an error word is a bare terminator
  a_error_is_term: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_error |-> result_last && (result_character == 16'd0))
    else $error("error word is not a terminator");

  // character zero marks exactly the last word of a run
  a_zero_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result_character == 16'd0) == result_last))
    else $error("terminator and character zero disagree");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while another is in work");

  // hold a stalled result word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_character)
      && $stable(result_last) && $stable(result_error))
    else $error("stalled result word changed");

endmodule

bind roman_numeral_index_formatter_unit rnif_checker u_rnif_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item.valid),
  .item_ready       (item.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_character (result.character),
  .result_last      (result.last),
  .result_error     (result.error)
);
